// ----- rtl/fedl_pkg.sv -----
// ----------------------------------------------------------------------------
// fedl_pkg
// Shared types and codes of the feedback echo delay line: register indexes,
// datapath operation codes, effect kinds and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package fedl_pkg;

  // Configuration register indexes.
  localparam logic [2:0] REG_ENABLE   = 3'd0;
  localparam logic [2:0] REG_MODE     = 3'd1;
  localparam logic [2:0] REG_TAPS     = 3'd2;
  localparam logic [2:0] REG_FB_GAIN  = 3'd3;
  localparam logic [2:0] REG_WET_GAIN = 3'd4;
  localparam logic [2:0] REG_LEVEL    = 3'd5;

  // Effect mode register codes.
  localparam logic [1:0] MODE_CLEAN = 2'd0;
  localparam logic [1:0] MODE_ECHO  = 2'd1;
  localparam logic [1:0] MODE_DELAY = 2'd2;

  // What the datapath will do with the current sample.
  localparam logic [1:0] KIND_PASS  = 2'd0;
  localparam logic [1:0] KIND_ECHO  = 2'd1;
  localparam logic [1:0] KIND_DELAY = 2'd2;

  // Datapath operation codes.
  localparam logic [4:0] OP_NOP   = 5'd0;
  localparam logic [4:0] OP_LOAD  = 5'd1;
  localparam logic [4:0] OP_QUOT  = 5'd2;
  localparam logic [4:0] OP_DIST  = 5'd3;
  localparam logic [4:0] OP_READ  = 5'd4;
  localparam logic [4:0] OP_CAPT  = 5'd5;
  localparam logic [4:0] OP_CLEAN = 5'd6;
  localparam logic [4:0] OP_DELAY = 5'd7;
  localparam logic [4:0] OP_E0    = 5'd8;
  localparam logic [4:0] OP_E1    = 5'd9;
  localparam logic [4:0] OP_E2    = 5'd10;
  localparam logic [4:0] OP_E3    = 5'd11;
  localparam logic [4:0] OP_E4    = 5'd12;
  localparam logic [4:0] OP_E5    = 5'd13;
  localparam logic [4:0] OP_SCALE = 5'd14;
  localparam logic [4:0] OP_OUT   = 5'd15;

  typedef struct packed {
    logic [4:0] op;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       out_free;
  } status_t;

endpackage

// ----- rtl/fedl_ram.sv -----
// ----------------------------------------------------------------------------
// fedl_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module fedl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/fedl_ctrl.sv -----
// ----------------------------------------------------------------------------
// fedl_ctrl
// Sequencer of the delay line: steps one sample through address calculation,
// store read, mode-specific mixing, output scaling and the output hand-off.
// ----------------------------------------------------------------------------
module fedl_ctrl
  import fedl_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  input  status_t status,
  output cmd_t    cmd
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_QUOT  = 4'd1;
  localparam logic [3:0] S_DIST  = 4'd2;
  localparam logic [3:0] S_READ  = 4'd3;
  localparam logic [3:0] S_CAPT  = 4'd4;
  localparam logic [3:0] S_CLEAN = 4'd5;
  localparam logic [3:0] S_DELAY = 4'd6;
  localparam logic [3:0] S_E0    = 4'd7;
  localparam logic [3:0] S_E1    = 4'd8;
  localparam logic [3:0] S_E2    = 4'd9;
  localparam logic [3:0] S_E3    = 4'd10;
  localparam logic [3:0] S_E4    = 4'd11;
  localparam logic [3:0] S_E5    = 4'd12;
  localparam logic [3:0] S_SCALE = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_QUOT;
        end
      end
      S_QUOT: begin
        cmd.op    = OP_QUOT;
        state_nxt = S_DIST;
      end
      S_DIST: begin
        cmd.op    = OP_DIST;
        state_nxt = S_READ;
      end
      S_READ: begin
        cmd.op    = OP_READ;
        state_nxt = S_CAPT;
      end
      S_CAPT: begin
        cmd.op = OP_CAPT;
        unique case (status.kind)
          KIND_ECHO:  state_nxt = S_E0;
          KIND_DELAY: state_nxt = S_DELAY;
          default:    state_nxt = S_CLEAN;
        endcase
      end
      S_CLEAN: begin
        cmd.op    = OP_CLEAN;
        state_nxt = S_SCALE;
      end
      S_DELAY: begin
        cmd.op    = OP_DELAY;
        state_nxt = S_SCALE;
      end
      S_E0: begin
        cmd.op    = OP_E0;
        state_nxt = S_E1;
      end
      S_E1: begin
        cmd.op    = OP_E1;
        state_nxt = S_E2;
      end
      S_E2: begin
        cmd.op    = OP_E2;
        state_nxt = S_E3;
      end
      S_E3: begin
        cmd.op    = OP_E3;
        state_nxt = S_E4;
      end
      S_E4: begin
        cmd.op    = OP_E4;
        state_nxt = S_E5;
      end
      S_E5: begin
        cmd.op    = OP_E5;
        state_nxt = S_SCALE;
      end
      S_SCALE: begin
        cmd.op    = OP_SCALE;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // Hold the finished sample until the output register is free.
        if (status.out_free) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ----- rtl/fedl_dp.sv -----
// ----------------------------------------------------------------------------
// fedl_dp
// Datapath of the delay line: configuration registers, write position and fill
// count, the delay store, one shared multiplier with accumulator, and the
// output register.
// ----------------------------------------------------------------------------
module fedl_dp
  import fedl_pkg::*;
#(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,
  input  cmd_t        cmd,
  output status_t     status
);

  localparam int AW    = $clog2(DELAY_DEPTH);
  localparam int FW    = $clog2(DELAY_DEPTH + 1);
  localparam int RECIP = (1 << 20) / DELAY_DEPTH;

  localparam logic [AW-1:0] WP_LAST   = AW'(DELAY_DEPTH - 1);
  localparam logic [FW-1:0] FILL_FULL = FW'(DELAY_DEPTH);
  localparam logic [AW:0]   DEPTH_X   = (AW + 1)'(DELAY_DEPTH);
  localparam logic [31:0]   DEPTH_W   = 32'(DELAY_DEPTH);
  localparam logic [19:0]   RECIP_W   = 20'(RECIP);

  // Configuration registers.
  logic        en_r;
  logic [1:0]  mode_r;
  logic [9:0]  taps_r;
  logic [15:0] fbg_r;
  logic [15:0] wetg_r;
  logic [9:0]  lvl_r;

  // Store bookkeeping: entries [0, fill_r) were written since the last clear.
  logic [AW-1:0] wp_r;
  logic [FW-1:0] fill_r;
  logic [AW-1:0] wp_inc;
  logic [FW-1:0] fill_inc;

  logic signed [15:0] x_r;
  logic signed [15:0] d_r;
  logic signed [15:0] s_r;
  logic [9:0]         q_r;
  logic [AW-1:0]      dist_r;
  logic               rd_valid_r;
  logic signed [33:0] prod_r;
  logic signed [18:0] acc_r;
  logic               out_valid_r;
  logic [31:0]        out_data_r;

  logic [15:0] fbc;
  logic [15:0] wgc;
  logic [15:0] omf;
  logic [15:0] omw;

  logic [29:0]        qprod;
  logic [31:0]        rem;
  logic [AW:0]        rp_ext;
  logic [AW-1:0]      rp;
  logic               rp_valid;

  logic signed [16:0] mul_a;
  logic signed [16:0] mul_b;
  logic signed [33:0] prod_nxt;
  logic signed [18:0] w_ext;

  logic signed [17:0] x18;
  logic signed [17:0] d18;
  logic signed [17:0] t_sum;
  logic signed [17:0] t_half;
  logic signed [17:0] xd_sum;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [15:0]        ram_wdata;
  logic [15:0]        ram_rdata;

  logic signed [11:0] y12;
  logic [15:0]        y16;

  // Product divided by 32768 with truncation toward zero.
  function automatic logic signed [17:0] weigh(input logic signed [33:0] p);
    logic signed [33:0] adj;
    logic signed [33:0] sh;
    adj = p[33] ? (p + 34'sd32767) : p;
    sh  = adj >>> 15;
    return sh[17:0];
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  // Gains above one saturate to one.
  assign fbc = (fbg_r > 16'd32768) ? 16'd32768 : fbg_r;
  assign wgc = (wetg_r > 16'd32768) ? 16'd32768 : wetg_r;
  assign omf = 16'd32768 - fbc;
  assign omw = 16'd32768 - wgc;

  assign wp_inc   = (wp_r == WP_LAST) ? '0 : wp_r + 1'b1;
  assign fill_inc = (fill_r == FILL_FULL) ? fill_r : fill_r + 1'b1;

  // Distance modulo the depth: reciprocal estimate, then one correction.
  always_comb begin
    qprod = 30'(taps_r) * 30'(RECIP_W);
    rem   = 32'(taps_r) - 32'(q_r) * DEPTH_W;
    if (rem >= DEPTH_W) begin
      rem = rem - DEPTH_W;
    end
  end

  // Read position behind the write position, wrapping at the depth.
  always_comb begin
    rp_ext = {1'b0, wp_r} + DEPTH_X - {1'b0, dist_r};
    if (rp_ext >= DEPTH_X) begin
      rp_ext = rp_ext - DEPTH_X;
    end
    rp       = rp_ext[AW-1:0];
    rp_valid = (fill_r == FILL_FULL) || (FW'(rp) < fill_r);
  end

  // Shared multiplier operand selection.
  always_comb begin
    unique case (cmd.op)
      OP_E0:    begin mul_a = {x_r[15], x_r}; mul_b = {1'b0, omf}; end
      OP_E1:    begin mul_a = {d_r[15], d_r}; mul_b = {1'b0, fbc}; end
      OP_E2:    begin mul_a = {x_r[15], x_r}; mul_b = {1'b0, omw}; end
      OP_E3:    begin mul_a = {d_r[15], d_r}; mul_b = {1'b0, wgc}; end
      OP_SCALE: begin
        // (s + 32768) is the offset-binary form of s.
        mul_a = {1'b0, ~s_r[15], s_r[14:0]};
        mul_b = {6'b0, lvl_r, 1'b0};
      end
      default:  begin mul_a = '0; mul_b = '0; end
    endcase
    prod_nxt = mul_a * mul_b;
    w_ext    = 19'(weigh(prod_r));
  end

  // Repeating delay mix.
  always_comb begin
    x18    = {{2{x_r[15]}}, x_r};
    d18    = {{2{d_r[15]}}, d_r};
    t_sum  = (x18 <<< 1) + d18;
    t_half = t_sum[17] ? ((t_sum + 18'sd1) >>> 1) : (t_sum >>> 1);
    xd_sum = x18 + d18;
  end

  // Store write port.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wp_r;
    ram_wdata = '0;
    unique case (cmd.op)
      OP_CLEAN: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
      end
      OP_DELAY: begin
        ram_we    = 1'b1;
        ram_wdata = sat16({t_half[17], t_half});
      end
      OP_E3: begin
        ram_we    = 1'b1;
        ram_wdata = sat16(acc_r);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  fedl_ram #(
    .WIDTH (16),
    .DEPTH (DELAY_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.op == OP_READ),
    .raddr (rp),
    .rdata (ram_rdata)
  );

  // Output mapping onto -level .. +level.
  always_comb begin
    y12 = {1'b0, prod_r[26:16]} - {2'b0, lvl_r};
    y16 = {{4{y12[11]}}, y12};
  end

  // Control state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      mode_r      <= MODE_ECHO;
      taps_r      <= 10'd500;
      fbg_r       <= 16'd24576;
      wetg_r      <= 16'd27853;
      lvl_r       <= 10'd512;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (cmd.op)
        OP_CLEAN: begin
          // Store cleared, zero written at position 0, position moves to 1.
          wp_r   <= WP_LAST == '0 ? '0 : AW'(1);
          fill_r <= FW'(1);
        end
        OP_DELAY, OP_E5: begin
          wp_r   <= wp_inc;
          fill_r <= fill_inc;
        end
        default: ;
      endcase
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ENABLE:   en_r   <= cfg_wdata[0];
          REG_MODE: begin
            mode_r <= cfg_wdata[1:0];
            wp_r   <= '0;
            fill_r <= '0;
          end
          REG_TAPS:     taps_r <= cfg_wdata[9:0];
          REG_FB_GAIN:  fbg_r  <= cfg_wdata;
          REG_WET_GAIN: wetg_r <= cfg_wdata;
          REG_LEVEL:    lvl_r  <= cfg_wdata[9:0];
          default:      en_r   <= en_r;
        endcase
      end
    end
  end

  // Sample payload.
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD:  x_r        <= in_tdata;
      OP_QUOT:  q_r        <= qprod[29:20];
      OP_DIST:  dist_r     <= rem[AW-1:0];
      OP_READ:  rd_valid_r <= rp_valid;
      OP_CAPT:  d_r        <= rd_valid_r ? ram_rdata : 16'sd0;
      OP_CLEAN: s_r        <= x_r;
      OP_DELAY: s_r        <= sat16({xd_sum[17], xd_sum});
      OP_E0:    prod_r     <= prod_nxt;
      OP_E1: begin
        prod_r <= prod_nxt;
        acc_r  <= w_ext;
      end
      OP_E2: begin
        prod_r <= prod_nxt;
        acc_r  <= acc_r + w_ext;
      end
      OP_E3: begin
        prod_r <= prod_nxt;
        acc_r  <= w_ext;
      end
      OP_E4:    acc_r      <= acc_r + w_ext;
      OP_E5:    s_r        <= sat16(acc_r);
      OP_SCALE: prod_r     <= prod_nxt;
      OP_OUT:   out_data_r <= {y16[7:0], ~y16[15], y16[14:8], y16};
      default:  x_r        <= x_r;
    endcase
  end

  always_comb begin
    status.out_free = !out_valid_r || out_tready;
    if (!en_r) begin
      status.kind = KIND_PASS;
    end else begin
      unique case (mode_r)
        MODE_ECHO:  status.kind = KIND_ECHO;
        MODE_DELAY: status.kind = KIND_DELAY;
        default:    status.kind = KIND_PASS;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ----- rtl/feedback_echo_delay_line.sv -----
// ----------------------------------------------------------------------------
// feedback_echo_delay_line
// Feedback echo / repeating delay effect on a 16-bit audio stream, with the
// result mapped onto a programmable level and split into PWM bytes.
//
//   Channel  Direction  Handshake           Payload
//   in_      input      in_tvalid/tready    in_tdata[15:0]  audio_in
//   out_     output     out_tvalid/tready   out_tdata[31:0] audio_out, pwm bytes
//   cfg_     input      cfg_we              cfg_index, cfg_wdata
//
// A sample goes from acceptance through the address, store read, mixing and
// scaling states to the output register; echo mode takes longer than clean
// or disabled operation and delay mode, as its four weighted products go
// through the one shared multiplier.
// The next sample is accepted once the previous one sits in the output
// register, even while that result is still stalled.
// After reset the store reads as all zero through a fill count; no clearing
// pass is needed, and a write to the mode register empties it the same way.
// ----------------------------------------------------------------------------
module feedback_echo_delay_line
  import fedl_pkg::*;
#(
  parameter int DELAY_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] audio_in
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // [15:0] audio_out, [23:16] pwm_high, [31:24] pwm_low
);

  cmd_t    cmd;
  status_t status;

  fedl_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  fedl_dp #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .status     (status)
  );

endmodule
